// ----- rtl/core/hkm_pkg.sv -----
// ----------------------------------------------------------------------------
// hkm_pkg
// Shared types, codes and helper functions of the hotkey matcher.
// ----------------------------------------------------------------------------
package hkm_pkg;

  localparam int unsigned SYM_W      = 29;
  localparam int unsigned MOD_W      = 8;
  localparam int unsigned ACT_W      = 8;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TMO_W      = 16;

  localparam logic [MOD_W-1:0] M_SHIFT  = 8'h01;
  localparam logic [MOD_W-1:0] M_LOCK   = 8'h02;
  localparam logic [MOD_W-1:0] M_CTRL   = 8'h04;
  localparam logic [MOD_W-1:0] M_MOD1   = 8'h08;
  localparam logic [MOD_W-1:0] M_MOD2   = 8'h10;
  localparam logic [MOD_W-1:0] M_MOD4   = 8'h40;
  localparam logic [MOD_W-1:0] M_IGNORE = M_LOCK | M_MOD2;

  localparam logic [SYM_W-1:0] CASE_BIT = 29'd32;
  localparam logic [SYM_W-1:0] LOW_A    = 29'h61;
  localparam logic [SYM_W-1:0] LOW_Z    = 29'h7A;

  localparam logic              WATCH_EN_RST  = 1'b0;
  localparam logic [MOD_W-1:0]  WATCH_MOD_RST = 8'd64;
  localparam logic [TMO_W-1:0]  WATCH_TMO_RST = 16'd300;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_PRESS   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_TICK    = 3'd3,
    OP_WRESET  = 3'd4
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE   = 3'd0,
    EV_MATCH  = 3'd1,
    EV_FIRED  = 3'd2,
    EV_ARMED  = 3'd3,
    EV_STORED = 3'd4,
    EV_FULL   = 3'd5
  } event_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_MODIFIER = 2'd1,
    CFG_TIMEOUT  = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [MOD_W-1:0] mods;
    logic [ACT_W-1:0] act;
  } entry_t;

  typedef struct packed {
    logic        decided;
    event_kind_e kind;
    logic        consumed;
  } watch_res_t;

  // letter test after folding to lower case
  function automatic logic is_letter(input logic [SYM_W-1:0] s);
    logic [SYM_W-1:0] f;
    f = s | CASE_BIT;
    return (f >= LOW_A) && (f <= LOW_Z);
  endfunction

  function automatic logic same_symbol(input logic [SYM_W-1:0] a,
                                       input logic [SYM_W-1:0] b);
    return (a == b) ||
           (is_letter(a) && is_letter(b) && ((a | CASE_BIT) == (b | CASE_BIT)));
  endfunction

  function automatic logic is_watched_key(input logic [SYM_W-1:0] s,
                                          input logic [MOD_W-1:0] mask);
    logic r;
    if ((mask & M_MOD4) != '0) begin
      r = (s == 29'hFFEB) || (s == 29'hFFEC) || (s == 29'hFFED) || (s == 29'hFFEE);
    end else if ((mask & M_MOD1) != '0) begin
      r = (s == 29'hFFE9) || (s == 29'hFFEA) || (s == 29'hFFE7) || (s == 29'hFFE8);
    end else if ((mask & M_CTRL) != '0) begin
      r = (s == 29'hFFE3) || (s == 29'hFFE4);
    end else if ((mask & M_SHIFT) != '0) begin
      r = (s == 29'hFFE1) || (s == 29'hFFE2);
    end else begin
      r = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/hkm_table.sv -----
// ----------------------------------------------------------------------------
// hkm_table
// Binding store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hkm_table
  import hkm_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IDX_W = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/hkm_watch.sv -----
// ----------------------------------------------------------------------------
// hkm_watch
// Lone modifier tap watcher and its configuration registers.
// ----------------------------------------------------------------------------
module hkm_watch
  import hkm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  exec_i,
  input  logic [OP_W-1:0]       op_i,
  input  logic [SYM_W-1:0]      sym_i,
  input  logic [MOD_W-1:0]      mod_i,
  output watch_res_t            res_o
);

  logic              enable_q;
  logic [MOD_W-1:0]  wmod_q;
  logic [TMO_W-1:0]  timeout_q;
  logic              armed_q, armed_d;
  logic              other_q, other_d;
  logic [TMO_W-1:0]  elapsed_q, elapsed_d;

  logic [MOD_W-1:0]  no_lock;
  logic [MOD_W-1:0]  mods;
  logic              watched;
  logic              arm_ok;
  logic [TMO_W-1:0]  elapsed_inc;
  logic              cfg_hit;

  assign no_lock     = mod_i & ~M_LOCK;
  assign mods        = no_lock & ~M_MOD2;
  assign watched     = (sym_i != '0) && is_watched_key(sym_i, wmod_q);
  assign arm_ok      = enable_q && watched && ((no_lock & wmod_q) == '0) &&
                       ((mods & ~wmod_q) == '0);
  assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
  assign cfg_hit     = cfg_we_i && ((cfg_index_i == CFG_ENABLE) ||
                       (cfg_index_i == CFG_MODIFIER) || (cfg_index_i == CFG_TIMEOUT));

  always_comb begin
    res_o     = '{decided: 1'b1, kind: EV_NONE, consumed: 1'b0};
    armed_d   = armed_q;
    other_d   = other_q;
    elapsed_d = elapsed_q;
    case (op_i)
      OP_PRESS: begin
        if (arm_ok) begin
          res_o     = '{decided: 1'b1, kind: EV_ARMED, consumed: 1'b1};
          armed_d   = 1'b1;
          other_d   = 1'b0;
          elapsed_d = '0;
        end else begin
          res_o.decided = 1'b0;
          if (armed_q) begin
            other_d = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if (armed_q) begin
          if (watched && !other_q) begin
            armed_d = 1'b0;
            res_o   = '{decided: 1'b1, kind: EV_FIRED, consumed: 1'b1};
          end else begin
            other_d = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (armed_q) begin
          elapsed_d = elapsed_inc;
          if (other_q) begin
            armed_d = 1'b0;
          end else if (elapsed_inc >= timeout_q) begin
            armed_d = 1'b0;
            res_o   = '{decided: 1'b1, kind: EV_FIRED, consumed: 1'b0};
          end
        end
      end
      OP_WRESET: begin
        armed_d = 1'b0;
        other_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= WATCH_EN_RST;
      wmod_q    <= WATCH_MOD_RST;
      timeout_q <= WATCH_TMO_RST;
      armed_q   <= 1'b0;
      other_q   <= 1'b0;
      elapsed_q <= '0;
    end else begin
      if (cfg_hit) begin
        armed_q <= 1'b0;
      end else if (exec_i) begin
        armed_q <= armed_d;
      end
      if (exec_i) begin
        other_q   <= other_d;
        elapsed_q <= elapsed_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ENABLE:   enable_q  <= cfg_data_i[0];
          CFG_MODIFIER: wmod_q    <= cfg_data_i[MOD_W-1:0];
          CFG_TIMEOUT:  timeout_q <= cfg_data_i[TMO_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/hotkey_matcher_with_modifier_tap.sv -----
// ----------------------------------------------------------------------------
// hotkey_matcher_with_modifier_tap
// Hotkey binding table with newest-first search and lone modifier tap watcher.
// ----------------------------------------------------------------------------
// An operation is taken when start_i is high and busy_o low. busy_o is high
// from the cycle after the transfer until the item is decided, and the one
// result is strobed on done_o for a single cycle right after busy_o falls; it
// cannot be held off. Add, release, tick, watcher reset and undefined codes
// keep busy_o high only for the execute state. A key press that neither arms
// the watcher nor has a zero keysym nor finds an empty table scans the binding
// memory newest first, one entry per cycle through its registered read port.
// A new item may start in the cycle that carries a result. Configuration
// writes are taken only while busy_o is low.
// ----------------------------------------------------------------------------
module hotkey_matcher_with_modifier_tap
  import hkm_pkg::*;
#(
  parameter int unsigned MAX_BINDINGS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  output logic                  done_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [SYM_W-1:0]      key_symbol_i,
  input  logic [SYM_W-1:0]      shifted_symbol_i,
  input  logic [MOD_W-1:0]      modifier_state_i,
  input  logic [SYM_W-1:0]      bind_symbol_i,
  input  logic [MOD_W-1:0]      bind_modifiers_i,
  input  logic [ACT_W-1:0]      bind_action_i,
  output logic [KIND_W-1:0]     event_kind_o,
  output logic                  consumed_o,
  output logic [ACT_W-1:0]      action_id_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BINDINGS + 1);

  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q;
  logic [SYM_W-1:0]  sym_q, shifted_q, bsym_q;
  logic [MOD_W-1:0]  mod_q, bmod_q;
  logic [ACT_W-1:0]  bact_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  logic              done_q, done_d;
  event_kind_e       kind_q, kind_d;
  logic              consumed_q, consumed_d;
  logic [ACT_W-1:0]  act_q, act_d;

  logic              accept;
  logic              exec;
  logic              we;
  entry_t            wdata;
  logic [IDX_W-1:0]  raddr;
  entry_t            rdata;
  watch_res_t        wres;

  logic [SYM_W-1:0]  alt_sym;
  logic [CNT_W-1:0]  count_m1;
  logic [IDX_W-1:0]  idx_m1;
  logic              press_search;
  logic              scan_hit;
  logic              scan_last;
  logic              table_full;

  assign accept      = start_i && !busy_o;
  assign exec        = (state_q == ST_EXEC);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy_o;

  assign count_m1   = count_q - 1'b1;
  assign idx_m1     = idx_q - 1'b1;
  assign raddr      = exec ? count_m1[IDX_W-1:0] : idx_m1;
  assign table_full = (count_q >= CNT_W'(MAX_BINDINGS));
  assign wdata      = '{sym: bsym_q, mods: bmod_q, act: bact_q};

  assign alt_sym      = ((mod_q & M_SHIFT) != '0) ? shifted_q : '0;
  assign press_search = (op_q == OP_PRESS) && !wres.decided &&
                        (sym_q != '0) && (count_q != '0);
  assign scan_hit     = ((mod_q & ~M_IGNORE) == rdata.mods) &&
                        (same_symbol(sym_q, rdata.sym) ||
                         ((alt_sym != '0) && same_symbol(alt_sym, rdata.sym)));
  assign scan_last    = (idx_q == '0);

  hkm_table #(
    .DEPTH (MAX_BINDINGS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  hkm_watch u_watch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .exec_i      (exec),
    .op_i        (op_q),
    .sym_i       (sym_q),
    .mod_i       (mod_q),
    .res_o       (wres)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = press_search ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    done_d     = 1'b0;
    kind_d     = EV_NONE;
    consumed_d = 1'b0;
    act_d      = '0;
    we         = 1'b0;
    count_d    = count_q;
    idx_d      = idx_q;
    case (state_q)
      ST_EXEC: begin
        if (op_q == OP_ADD) begin
          done_d = 1'b1;
          if (bsym_q == '0) begin
            kind_d = EV_NONE;
          end else if (table_full) begin
            kind_d = EV_FULL;
          end else begin
            we      = 1'b1;
            count_d = count_q + 1'b1;
            kind_d  = EV_STORED;
          end
        end else if (press_search) begin
          idx_d = count_m1[IDX_W-1:0];
        end else begin
          done_d     = 1'b1;
          kind_d     = wres.kind;
          consumed_d = wres.consumed;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          done_d     = 1'b1;
          kind_d     = EV_MATCH;
          consumed_d = 1'b1;
          act_d      = rdata.act;
        end else if (scan_last) begin
          done_d = 1'b1;
        end else begin
          idx_d = idx_m1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= operation_i;
      sym_q     <= key_symbol_i;
      shifted_q <= shifted_symbol_i;
      mod_q     <= modifier_state_i;
      bsym_q    <= bind_symbol_i;
      bmod_q    <= bind_modifiers_i;
      bact_q    <= bind_action_i;
    end
    idx_q      <= idx_d;
    kind_q     <= kind_d;
    consumed_q <= consumed_d;
    act_q      <= act_d;
  end

  assign done_o       = done_q;
  assign event_kind_o = kind_q;
  assign consumed_o   = consumed_q;
  assign action_id_o  = act_q;

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held two cycles");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result shown while busy");

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_BINDINGS)) else $error("binding count overflow");

  a_match_consumed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (event_kind_o == EV_MATCH)) |-> consumed_o)
    else $error("match not consumed");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("accepted item left no busy cycle");

endmodule

// ----- tb/hotkey_matcher_with_modifier_tap_tb.sv -----
// ----------------------------------------------------------------------------
// hotkey_matcher_with_modifier_tap_tb
// Self-checking bench for the hotkey matcher and its lone modifier tap watcher.
// Directed tests cover binding storage, newest-first matching with ignored
// and extra modifiers, case folding and the shifted column, and the watcher's
// release, timeout, cancel and reset paths. Random traffic then runs several
// register settings, fills the binding table and keeps it busy. A predictor
// computes each result at the input transfer, and every strobed result is
// compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hotkey_matcher_with_modifier_tap_tb;
  import hkm_pkg::*;

  localparam int unsigned TABLE_DEPTH = 32;

  localparam logic [SYM_W-1:0] CH_LA    = 29'h61;
  localparam logic [SYM_W-1:0] CH_LZ    = 29'h7A;
  localparam logic [SYM_W-1:0] CH_UA    = 29'h41;
  localparam logic [SYM_W-1:0] CH_UZ    = 29'h5A;
  localparam logic [SYM_W-1:0] CASE_GAP = 29'd32;
  localparam logic [SYM_W-1:0] SYM_MAX  = 29'h1FFF_FFFF;

  localparam logic [SYM_W-1:0] KS_SHIFT_L   = 29'hFFE1;
  localparam logic [SYM_W-1:0] KS_SHIFT_R   = 29'hFFE2;
  localparam logic [SYM_W-1:0] KS_CONTROL_L = 29'hFFE3;
  localparam logic [SYM_W-1:0] KS_CONTROL_R = 29'hFFE4;
  localparam logic [SYM_W-1:0] KS_META_L    = 29'hFFE7;
  localparam logic [SYM_W-1:0] KS_ALT_R     = 29'hFFEA;
  localparam logic [SYM_W-1:0] KS_SUPER_L   = 29'hFFEB;
  localparam logic [SYM_W-1:0] KS_SUPER_R   = 29'hFFEC;
  localparam logic [SYM_W-1:0] KS_HYPER_L   = 29'hFFED;
  localparam logic [SYM_W-1:0] KS_HYPER_R   = 29'hFFEE;

  localparam logic [OP_W-1:0]      OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0]      OP_UNDEF_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] shifted;
    logic [MOD_W-1:0] mstate;
    logic [SYM_W-1:0] bsym;
    logic [MOD_W-1:0] bmods;
    logic [ACT_W-1:0] bact;
  } key_item_t;

  typedef struct {
    event_kind_e      kind;
    logic             consumed;
    logic [ACT_W-1:0] act;
  } hk_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic                  done_o;
  logic [OP_W-1:0]       operation_i = '0;
  logic [SYM_W-1:0]      key_symbol_i = '0;
  logic [SYM_W-1:0]      shifted_symbol_i = '0;
  logic [MOD_W-1:0]      modifier_state_i = '0;
  logic [SYM_W-1:0]      bind_symbol_i = '0;
  logic [MOD_W-1:0]      bind_modifiers_i = '0;
  logic [ACT_W-1:0]      bind_action_i = '0;
  logic [KIND_W-1:0]     event_kind_o;
  logic                  consumed_o;
  logic [ACT_W-1:0]      action_id_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // predictor state
  logic [SYM_W-1:0] bind_sym  [TABLE_DEPTH];
  logic [MOD_W-1:0] bind_mods [TABLE_DEPTH];
  logic [ACT_W-1:0] bind_act  [TABLE_DEPTH];
  int unsigned      bind_count = 0;
  logic             tap_enable = WATCH_EN_RST;
  logic [MOD_W-1:0] tap_mask = WATCH_MOD_RST;
  logic [TMO_W-1:0] tap_timeout = WATCH_TMO_RST;
  logic             tap_armed = 1'b0;
  logic             tap_spoiled = 1'b0;
  logic [TMO_W-1:0] tap_ticks = '0;

  hk_result_t pending_events[$];
  int         error_count = 0;
  int         items_sent = 0;
  bit         sender_gaps = 1'b1;

  hotkey_matcher_with_modifier_tap #(
    .MAX_BINDINGS(TABLE_DEPTH)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .operation_i     (operation_i),
    .key_symbol_i    (key_symbol_i),
    .shifted_symbol_i(shifted_symbol_i),
    .modifier_state_i(modifier_state_i),
    .bind_symbol_i   (bind_symbol_i),
    .bind_modifiers_i(bind_modifiers_i),
    .bind_action_i   (bind_action_i),
    .event_kind_o    (event_kind_o),
    .consumed_o      (consumed_o),
    .action_id_o     (action_id_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic is_lower(logic [SYM_W-1:0] s);
    return (s >= CH_LA) && (s <= CH_LZ);
  endfunction

  function automatic logic is_upper(logic [SYM_W-1:0] s);
    return (s >= CH_UA) && (s <= CH_UZ);
  endfunction

  function automatic logic sym_equal(logic [SYM_W-1:0] a, logic [SYM_W-1:0] b);
    if (a == b) return 1'b1;
    if (is_lower(a) && is_upper(b)) return a == b + CASE_GAP;
    if (is_upper(a) && is_lower(b)) return a + CASE_GAP == b;
    return 1'b0;
  endfunction

  function automatic logic tap_key_hit(logic [SYM_W-1:0] s, logic [MOD_W-1:0] mask);
    if ((mask & M_MOD4) != '0) return (s >= KS_SUPER_L) && (s <= KS_HYPER_R);
    if ((mask & M_MOD1) != '0) return (s >= KS_META_L) && (s <= KS_ALT_R);
    if ((mask & M_CTRL) != '0) return (s == KS_CONTROL_L) || (s == KS_CONTROL_R);
    if ((mask & M_SHIFT) != '0) return (s == KS_SHIFT_L) || (s == KS_SHIFT_R);
    return 1'b0;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ENABLE: begin
        tap_enable = data[0];
        tap_armed  = 1'b0;
      end
      CFG_MODIFIER: begin
        tap_mask  = data[MOD_W-1:0];
        tap_armed = 1'b0;
      end
      CFG_TIMEOUT: begin
        tap_timeout = data[TMO_W-1:0];
        tap_armed   = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic hk_result_t predict_hotkey_event(key_item_t it);
    hk_result_t       r;
    logic [MOD_W-1:0] no_lock;
    logic [MOD_W-1:0] mods;
    logic [MOD_W-1:0] held;
    logic [MOD_W-1:0] need;
    logic [SYM_W-1:0] alt;
    logic             done;
    r.kind     = EV_NONE;
    r.consumed = 1'b0;
    r.act      = '0;
    case (it.op)
      OP_ADD: begin
        if (it.bsym == '0) begin
          r.kind = EV_NONE;
        end else if (bind_count >= TABLE_DEPTH) begin
          r.kind = EV_FULL;
        end else begin
          bind_sym[bind_count]  = it.bsym;
          bind_mods[bind_count] = it.bmods;
          bind_act[bind_count]  = it.bact;
          bind_count++;
          r.kind = EV_STORED;
        end
      end
      OP_PRESS: begin
        done    = 1'b0;
        alt     = ((it.mstate & M_SHIFT) != '0) ? it.shifted : '0;
        no_lock = it.mstate & ~M_LOCK;
        if (tap_enable && it.sym != '0 && tap_key_hit(it.sym, tap_mask)) begin
          mods = no_lock & ~M_MOD2;
          if ((no_lock & tap_mask) == '0 && (mods & ~tap_mask) == '0) begin
            tap_armed   = 1'b1;
            tap_spoiled = 1'b0;
            tap_ticks   = '0;
            r.kind      = EV_ARMED;
            r.consumed  = 1'b1;
            done        = 1'b1;
          end
        end
        if (!done) begin
          if (tap_armed) tap_spoiled = 1'b1;
          if (it.sym != '0) begin
            held = it.mstate & ~M_IGNORE;
            for (int i = int'(bind_count) - 1; i >= 0 && !done; i--) begin
              need = bind_mods[i];
              if ((held & need) == need && (held & ~need) == '0 &&
                  (sym_equal(it.sym, bind_sym[i]) ||
                   (alt != '0 && sym_equal(alt, bind_sym[i])))) begin
                r.kind     = EV_MATCH;
                r.consumed = 1'b1;
                r.act      = bind_act[i];
                done       = 1'b1;
              end
            end
          end
        end
      end
      OP_RELEASE: begin
        if (tap_armed) begin
          if (it.sym != '0 && tap_key_hit(it.sym, tap_mask) && !tap_spoiled) begin
            tap_armed  = 1'b0;
            r.kind     = EV_FIRED;
            r.consumed = 1'b1;
          end else begin
            tap_spoiled = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (tap_armed) begin
          if (tap_ticks != '1) tap_ticks++;
          if (tap_spoiled) begin
            tap_armed = 1'b0;
          end else if (tap_ticks >= tap_timeout) begin
            tap_armed = 1'b0;
            r.kind    = EV_FIRED;
          end
        end
      end
      OP_WRESET: begin
        tap_armed   = 1'b0;
        tap_spoiled = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // result checker: the receiver takes every strobe
  always @(posedge clk_i) begin
    hk_result_t want;
    if (rst_ni && done_o) begin
      if (pending_events.size() == 0) begin
        $display("%0t: result with nothing pending: kind %0d consumed %0d action %0d",
                 $time, event_kind_o, consumed_o, action_id_o);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind_o !== want.kind) begin
          $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, event_kind_o);
          error_count++;
        end
        if (consumed_o !== want.consumed) begin
          $display("%0t: consumed expected %0d actual %0d", $time, want.consumed, consumed_o);
          error_count++;
        end
        if (action_id_o !== want.act) begin
          $display("%0t: action_id expected %0h actual %0h", $time, want.act, action_id_o);
          error_count++;
        end
      end
    end
  end

  function automatic key_item_t random_item();
    key_item_t it;
    it.op      = OP_W'($urandom_range(0, 7));
    it.sym     = SYM_W'($urandom());
    it.shifted = SYM_W'($urandom());
    it.mstate  = MOD_W'($urandom());
    it.bsym    = SYM_W'($urandom());
    it.bmods   = MOD_W'($urandom());
    it.bact    = ACT_W'($urandom());
    return it;
  endfunction

  function automatic logic [SYM_W-1:0] flip_case(logic [SYM_W-1:0] s);
    if ((is_lower(s) || is_upper(s)) && $urandom_range(0, 1) == 1) return s ^ CASE_GAP;
    return s;
  endfunction

  function automatic logic [SYM_W-1:0] random_letter();
    return flip_case(CH_LA + SYM_W'($urandom_range(0, 25)));
  endfunction

  function automatic logic [SYM_W-1:0] tap_key_for(logic [MOD_W-1:0] mask);
    if ((mask & M_MOD4) != '0) return SYM_W'($urandom_range(KS_SUPER_L, KS_HYPER_R));
    if ((mask & M_MOD1) != '0) return SYM_W'($urandom_range(KS_META_L, KS_ALT_R));
    if ((mask & M_CTRL) != '0) return SYM_W'($urandom_range(KS_CONTROL_L, KS_CONTROL_R));
    if ((mask & M_SHIFT) != '0) return SYM_W'($urandom_range(KS_SHIFT_L, KS_SHIFT_R));
    return SYM_W'($urandom_range(KS_SHIFT_L, KS_HYPER_R));
  endfunction

  function automatic logic [SYM_W-1:0] random_bind_symbol();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return random_letter();
      4, 5:    return 29'hFF00 | SYM_W'($urandom_range(0, 255));
      default: return SYM_W'($urandom());
    endcase
  endfunction

  function automatic logic [MOD_W-1:0] random_bind_mods();
    case ($urandom_range(0, 8))
      0:       return '0;
      1:       return M_SHIFT;
      2:       return M_CTRL;
      3:       return M_MOD1;
      4:       return M_MOD4;
      5:       return M_CTRL | M_SHIFT;
      6:       return M_CTRL | M_MOD1;
      default: return MOD_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input key_item_t it);
    if (sender_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 7)) @(posedge clk_i);
    @(posedge clk_i);
    start_i          <= 1'b1;
    operation_i      <= it.op;
    key_symbol_i     <= it.sym;
    shifted_symbol_i <= it.shifted;
    modifier_state_i <= it.mstate;
    bind_symbol_i    <= it.bsym;
    bind_modifiers_i <= it.bmods;
    bind_action_i    <= it.bact;
    do @(posedge clk_i); while (busy_o);
    start_i <= 1'b0;
    pending_events.push_back(predict_hotkey_event(it));
    items_sent++;
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] data;
    wait_drained();
    data = CFG_DATA_W'($urandom());
    case (idx)
      CFG_ENABLE:   data[0] = value[0];
      CFG_MODIFIER: data[MOD_W-1:0] = value[MOD_W-1:0];
      default:      data = value;
    endcase
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_cfg(idx, data);
  endtask

  task automatic add_binding(input logic [SYM_W-1:0] bsym, input logic [MOD_W-1:0] bmods,
                             input logic [ACT_W-1:0] bact);
    key_item_t it;
    it       = random_item();
    it.op    = OP_ADD;
    it.bsym  = bsym;
    it.bmods = bmods;
    it.bact  = bact;
    send_item(it);
  endtask

  task automatic press_key(input logic [SYM_W-1:0] sym, input logic [SYM_W-1:0] shifted,
                           input logic [MOD_W-1:0] mstate);
    key_item_t it;
    it         = random_item();
    it.op      = OP_PRESS;
    it.sym     = sym;
    it.shifted = shifted;
    it.mstate  = mstate;
    send_item(it);
  endtask

  task automatic key_op(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
    key_item_t it;
    it     = random_item();
    it.op  = op;
    it.sym = sym;
    send_item(it);
  endtask

  task automatic test_bindings();
    add_binding('0, M_CTRL, 8'h33);
    add_binding(CH_LA, M_CTRL, 8'h11);
    add_binding(29'h51, '0, 8'hFF);
    add_binding(SYM_MAX, 8'hFF, 8'h00);
    add_binding(29'h78, M_SHIFT | M_MOD1, 8'h5A);
    press_key(CH_UA, SYM_W'($urandom()), M_CTRL | M_LOCK | M_MOD2);
    add_binding(CH_UA, M_CTRL, 8'h22);
    press_key(CH_LA, SYM_W'($urandom()), M_CTRL);
    press_key(CH_LA, SYM_W'($urandom()), M_CTRL | M_MOD1);
    press_key(29'h71, SYM_W'($urandom()), '0);
    press_key(29'h07, 29'h58, M_SHIFT | M_MOD1);
    press_key('0, 29'h78, M_SHIFT | M_MOD1);
    press_key(SYM_MAX, SYM_MAX, 8'hFF);
    key_op(OP_RELEASE, KS_SUPER_L);
    key_op(OP_TICK, SYM_W'($urandom()));
    for (int c = OP_UNDEF_LO; c <= OP_UNDEF_HI; c++) key_op(OP_W'(c), SYM_W'($urandom()));
  endtask

  task automatic test_tap_release();
    write_cfg(CFG_ENABLE, 16'd1);
    write_cfg(CFG_MODIFIER, CFG_DATA_W'(M_MOD4));
    write_cfg(CFG_TIMEOUT, 16'd3);
    press_key(KS_SUPER_L, SYM_W'($urandom()), '0);
    key_op(OP_RELEASE, KS_SUPER_L);
    press_key(KS_SUPER_R, SYM_W'($urandom()), M_LOCK | M_MOD2);
    press_key(29'h71, SYM_W'($urandom()), '0);
    key_op(OP_RELEASE, KS_SUPER_R);
    press_key(KS_HYPER_L, SYM_W'($urandom()), M_CTRL);
    press_key(KS_HYPER_R, SYM_W'($urandom()), M_MOD4);
  endtask

  task automatic test_tap_timeout();
    press_key(KS_SUPER_L, SYM_W'($urandom()), '0);
    repeat (3) key_op(OP_TICK, SYM_W'($urandom()));
    press_key(KS_SUPER_R, SYM_W'($urandom()), '0);
    key_op(OP_RELEASE, KS_SHIFT_L);
    key_op(OP_TICK, SYM_W'($urandom()));
    press_key(KS_HYPER_L, SYM_W'($urandom()), '0);
    key_op(OP_WRESET, SYM_W'($urandom()));
    key_op(OP_TICK, SYM_W'($urandom()));
    write_cfg(CFG_TIMEOUT, 16'd0);
    press_key(KS_SUPER_L, SYM_W'($urandom()), '0);
    key_op(OP_TICK, SYM_W'($urandom()));
  endtask

  task automatic random_burst();
    key_item_t        it;
    int unsigned      idx;
    int               pick;
    logic [SYM_W-1:0] tap_key;
    it   = random_item();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it.op    = OP_ADD;
      it.bsym  = random_bind_symbol();
      it.bmods = random_bind_mods();
      send_item(it);
    end else if (pick < 50 && bind_count != 0) begin
      idx       = $urandom_range(0, bind_count - 1);
      it.op     = OP_PRESS;
      it.mstate = (bind_mods[idx] & ~M_IGNORE) | (it.mstate & M_IGNORE);
      if ($urandom_range(0, 6) == 0) it.mstate = it.mstate ^ (8'h01 << $urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) begin
        it.shifted = flip_case(bind_sym[idx]);
        it.sym     = random_letter();
        it.mstate |= M_SHIFT;
      end else begin
        it.sym = flip_case(bind_sym[idx]);
      end
      send_item(it);
    end else if (pick < 65) begin
      tap_key = tap_key_for(tap_mask);
      it.op   = OP_PRESS;
      it.sym  = tap_key;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: it.mstate = '0;
        5, 6, 7:       it.mstate = it.mstate & M_IGNORE;
        default:       ;
      endcase
      send_item(it);
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 4))
          0, 1, 2: key_op(OP_TICK, SYM_W'($urandom()));
          3:       press_key(random_letter(), SYM_W'($urandom()),
                             MOD_W'($urandom_range(0, 255)));
          default: key_op(OP_RELEASE, tap_key_for(tap_mask));
        endcase
      end
      if ($urandom_range(0, 1) == 1) key_op(OP_RELEASE, tap_key);
      else repeat ($urandom_range(1, 10)) key_op(OP_TICK, SYM_W'($urandom()));
    end else if (pick < 80) begin
      case ($urandom_range(0, 2))
        0:       key_op(OP_TICK, SYM_W'($urandom()));
        1:       key_op(OP_RELEASE, ($urandom_range(0, 1) == 1) ? tap_key_for(tap_mask) : it.sym);
        default: key_op(OP_WRESET, SYM_W'($urandom()));
      endcase
    end else if (pick < 90) begin
      send_item(it);
    end else begin
      it.op = OP_PRESS;
      if ($urandom_range(0, 1) == 1) it.sym = random_letter();
      send_item(it);
    end
  endtask

  task automatic test_random_traffic();
    int               target;
    logic [MOD_W-1:0] mask;
    logic [TMO_W-1:0] tmo;
    for (int phase = 0; phase < 7; phase++) begin
      sender_gaps = (phase == 0) || (phase == 2) || (phase == 4) || (phase == 5);
      case (phase)
        0:       begin mask = M_MOD4;  tmo = 16'd2; end
        1:       begin mask = M_MOD1;  tmo = 16'd0; end
        2:       begin mask = M_CTRL;  tmo = 16'd1; end
        3:       begin mask = M_SHIFT; tmo = 16'hFFFF; end
        4:       begin mask = 8'hFF;   tmo = TMO_W'($urandom_range(0, 8)); end
        5:       begin mask = 8'h00;   tmo = TMO_W'($urandom_range(1, 4)); end
        default: begin
          mask = MOD_W'($urandom_range(0, 255));
          tmo  = TMO_W'($urandom_range(0, 6));
        end
      endcase
      write_cfg(CFG_UNUSED, CFG_DATA_W'($urandom()));
      write_cfg(CFG_ENABLE, (phase == 4) ? 16'd0 : 16'd1);
      write_cfg(CFG_MODIFIER, CFG_DATA_W'(mask));
      write_cfg(CFG_TIMEOUT, tmo);
      target = items_sent + 200;
      while (items_sent < target) random_burst();
    end
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_bindings();
    test_tap_release();
    test_tap_timeout();
    test_random_traffic();
    waited = 0;
    while (pending_events.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (pending_events.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_events.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/hkm_pkg.sv
rtl/core/hkm_table.sv
rtl/core/hkm_watch.sv
rtl/core/hotkey_matcher_with_modifier_tap.sv
tb/hotkey_matcher_with_modifier_tap_tb.sv
